>>> rtl/bhpq_pkg.sv
// Shared types, widths, codes and index helpers for the binary heap priority queue.
// Used by the top level, the checker and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

  localparam int HEAP_DEPTH = 256;
  localparam int TAG_WIDTH  = 32;
  localparam int KEY_W      = 64;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int CHILD_W    = ADDR_W + 2;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;

  localparam int IN_DATA_W  = ((KEY_W + TAG_WIDTH + 7) / 8) * 8;
  localparam int IN_PAD_W   = IN_DATA_W - KEY_W - TAG_WIDTH;
  localparam int OUT_RAW_W  = KEY_W + TAG_WIDTH + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  function automatic logic wins(input logic mode, input logic [KEY_W-1:0] a,
                                input logic [KEY_W-1:0] b);
    return mode ? (a > b) : (a < b);
  endfunction

  function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] pos);
    logic [ADDR_W-1:0] dec;
    dec = pos - 1'b1;
    return dec >> 1;
  endfunction

  function automatic logic [CHILD_W-1:0] left_of(input logic [ADDR_W-1:0] pos);
    return {1'b0, pos, 1'b1};
  endfunction

  function automatic logic [CHILD_W-1:0] right_of(input logic [ADDR_W-1:0] pos);
    return {1'b0, pos, 1'b1} + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bhpq_ram.sv
// Generic synchronous RAM: one write port, two read ports with registered read data.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

>>> rtl/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: control sequencer and entry store.
// Depends on bhpq_pkg and bhpq_ram.
//
//   channel | ports              | word contents (lowest bit first)
//   --------+--------------------+-----------------------------------------------
//   input   | in_tvalid/tready   | tdata: item_key, item_tag; tuser: func
//   output  | out_tvalid/tready  | tdata: out_key, out_tag, occupancy; tuser: status
//   config  | cfg_valid/ready    | cfg_data: order_mode
//
// One word is processed at a time. Insert climbs one level per parent read; pop reads the
// root and the last entry, then descends level by level unless it removed the last entry;
// peek reads only the root, and any rejected, empty or unused-code case goes straight to
// the result. Each level waits on a registered RAM read.
// Reset is synchronous and active low; the store needs no clearing pass.
// A stalled output holds the block in its final state until the word is taken.
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bhpq_pkg::IN_DATA_W-1:0]     in_tdata,   // item_key, item_tag
  input  logic [bhpq_pkg::FUNC_W-1:0]        in_tuser,   // func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bhpq_pkg::OUT_DATA_W-1:0]    out_tdata,  // out_key, out_tag, occupancy
  output logic [bhpq_pkg::STATUS_W-1:0]      out_tuser,  // status
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data
);

  import bhpq_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_UP    = 3'd2;
  localparam logic [2:0] ST_DOWN  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  entry_t               cur_r, cur_nxt;
  logic                 pop_r, pop_nxt;
  logic [KEY_W-1:0]     res_key_r, res_key_nxt;
  logic [TAG_WIDTH-1:0] res_tag_r, res_tag_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                 order_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 emit_go;

  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  entry_t               wr_data;
  logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b;
  entry_t               rd_data_a, rd_data_b;

  logic [CHILD_W-1:0]   lc_cur, rc_cur, lc_next, rc_next;
  logic                 lc_ok, rc_ok, take_l, take_r;
  logic [KEY_W-1:0]     best_key;

  bhpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (HEAP_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign cfg_ready = rst_n && (state_r == ST_IDLE);

  assign lc_cur   = left_of(pos_r);
  assign rc_cur   = right_of(pos_r);
  assign lc_ok    = lc_cur < {1'b0, count_r};
  assign rc_ok    = rc_cur < {1'b0, count_r};
  assign take_l   = lc_ok && wins(order_r, rd_data_a.key, cur_r.key);
  assign best_key = take_l ? rd_data_a.key : cur_r.key;
  assign take_r   = rc_ok && wins(order_r, rd_data_b.key, best_key);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    pop_nxt        = pop_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = cur_r;
    rd_addr_a      = lc_cur[ADDR_W-1:0];
    rd_addr_b      = rc_cur[ADDR_W-1:0];
    emit_go        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          res_key_nxt    = '0;
          res_tag_nxt    = '0;
          res_status_nxt = STAT_DONE;
          pop_nxt        = (in_tuser == FUNC_POP);
          state_nxt      = ST_EMIT;
          unique case (in_tuser) inside
            FUNC_INSERT: begin
              if (count_r == CNT_W'(HEAP_DEPTH)) begin
                res_status_nxt = STAT_FULL;
              end else begin
                cur_nxt.key = in_tdata[KEY_W-1:0];
                cur_nxt.tag = in_tdata[KEY_W +: TAG_WIDTH];
                pos_nxt     = count_r[ADDR_W-1:0];
                count_nxt   = count_r + 1'b1;
                rd_addr_a   = parent_of(count_r[ADDR_W-1:0]);
                state_nxt   = ST_UP;
              end
            end
            FUNC_POP, FUNC_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                rd_addr_a = '0;
                rd_addr_b = ADDR_W'(count_r - 1'b1);
                state_nxt = ST_FETCH;
              end
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_FETCH: begin
        res_key_nxt = rd_data_a.key;
        res_tag_nxt = rd_data_a.tag;
        state_nxt   = ST_EMIT;
        if (pop_r) begin
          count_nxt = count_r - 1'b1;
          if (count_r != CNT_W'(1)) begin
            cur_nxt   = rd_data_b;
            pos_nxt   = '0;
            state_nxt = ST_DOWN;
          end
        end
      end
      ST_UP: begin
        wr_en = 1'b1;
        if (pos_r == '0 || !wins(order_r, cur_r.key, rd_data_a.key)) begin
          state_nxt = ST_EMIT;
        end else begin
          wr_data   = rd_data_a;
          pos_nxt   = parent_of(pos_r);
          rd_addr_a = parent_of(pos_nxt);
        end
      end
      ST_DOWN: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rd_data_b;
          pos_nxt = rc_cur[ADDR_W-1:0];
        end else if (take_l) begin
          wr_data = rd_data_a;
          pos_nxt = lc_cur[ADDR_W-1:0];
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          emit_go   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    lc_next = left_of(pos_nxt);
    rc_next = right_of(pos_nxt);
    if (state_r == ST_FETCH || state_r == ST_DOWN) begin
      rd_addr_a = lc_next[ADDR_W-1:0];
      rd_addr_b = rc_next[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_data;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    pop_r        <= pop_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    res_status_r <= res_status_nxt;
    if (emit_go) begin
      out_data_r   <= {{OUT_PAD_W{1'b0}}, count_r, res_tag_r, res_key_r};
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

>>> rtl/bhpq_checker.sv
// Port-level checker for the binary heap priority queue, bound to the top level.
// Depends on bhpq_pkg and binary_heap_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bhpq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [bhpq_pkg::STATUS_W-1:0]   out_tuser
);

  import bhpq_pkg::*;

  localparam int OCC_LO = KEY_W + TAG_WIDTH;

  logic [CNT_W-1:0] occ;
  assign occ = out_tdata[OCC_LO +: CNT_W];

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ <= CNT_W'(HEAP_DEPTH))
    else $error("occupancy beyond heap depth");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_EMPTY |-> occ == '0 && out_tdata[OCC_LO-1:0] == '0)
    else $error("empty status with entries or data");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_FULL |-> occ == CNT_W'(HEAP_DEPTH))
    else $error("full status while heap not full");

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> test/binary_heap_priority_queue_tb.sv
// Self-checking testbench for binary_heap_priority_queue: table-driven opening words,
// then random insert, pop, peek and unused-code traffic checked against a behavioral heap predictor.
// Depends on bhpq_pkg and the binary_heap_priority_queue RTL.
`timescale 1ns / 1ps

module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 20;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [TAG_WIDTH-1:0] tag;
    logic [STATUS_W-1:0]  status;
    logic [CNT_W-1:0]     occupancy;
  } result_t;

  typedef struct {
    logic [FUNC_W-1:0]    func;
    logic [KEY_W-1:0]     key;
    logic [TAG_WIDTH-1:0] tag;
    bit                   typed;
    result_t              want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;

  // Predicted heap contents and order setting.
  logic [KEY_W-1:0]     model_keys [HEAP_DEPTH];
  logic [TAG_WIDTH-1:0] model_tags [HEAP_DEPTH];
  int unsigned          model_count;
  logic                 model_larger_first;

  result_t   pending_results [$];
  stim_row_t opening_rows [20];

  bit idle_on;
  int errors;
  int results_seen;
  int words_sent;
  int n_insert, n_pop, n_peek, n_full, n_empty;

  always #6 clk = ~clk;

  binary_heap_priority_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic bit key_beats(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    return model_larger_first ? (a > b) : (a < b);
  endfunction

  function automatic result_t predict_step(input logic [FUNC_W-1:0] func,
                                           input logic [KEY_W-1:0] key,
                                           input logic [TAG_WIDTH-1:0] tag);
    result_t              r;
    int unsigned          pos, par, lc, rc, best;
    logic [KEY_W-1:0]     k;
    logic [TAG_WIDTH-1:0] t;
    r = '0;
    case (func)
      FUNC_INSERT: begin
        n_insert++;
        if (model_count >= HEAP_DEPTH) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          pos = model_count;
          model_count++;
          while (pos > 0) begin
            par = (pos - 1) >> 1;
            if (!key_beats(key, model_keys[par])) break;
            model_keys[pos] = model_keys[par];
            model_tags[pos] = model_tags[par];
            pos = par;
          end
          model_keys[pos] = key;
          model_tags[pos] = tag;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (func == FUNC_POP) n_pop++;
        else n_peek++;
        if (model_count == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          r.key = model_keys[0];
          r.tag = model_tags[0];
          if (func == FUNC_POP) begin
            model_count--;
            if (model_count > 0) begin
              model_keys[0] = model_keys[model_count];
              model_tags[0] = model_tags[model_count];
              pos = 0;
              forever begin
                lc = 2 * pos + 1;
                rc = lc + 1;
                best = pos;
                if (lc < model_count && key_beats(model_keys[lc], model_keys[pos])) best = lc;
                if (rc < model_count && key_beats(model_keys[rc], model_keys[best])) best = rc;
                if (best == pos) break;
                k = model_keys[pos];
                t = model_tags[pos];
                model_keys[pos] = model_keys[best];
                model_tags[pos] = model_tags[best];
                model_keys[best] = k;
                model_tags[best] = t;
                pos = best;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.occupancy = CNT_W'(model_count);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return '0;
      1: return '1;
      2, 3, 4: return KEY_W'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic offer_word(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                            input logic [TAG_WIDTH-1:0] tag, input bit typed,
                            input result_t want);
    result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({tag, key});
    in_tuser  <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_step(func, key, tag);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  task automatic offer_random(input logic [FUNC_W-1:0] func);
    offer_word(func, random_key(), $urandom, 1'b0, '0);
  endtask

  task automatic run_mixed(input int count);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) offer_random(FUNC_INSERT);
      else if (roll < 80) offer_random(FUNC_POP);
      else if (roll < 95) offer_random(FUNC_PEEK);
      else offer_random(FUNC_UNUSED);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_order_mode(input logic larger_first);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= larger_first;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_larger_first = larger_first;
  endtask

  task automatic check_result();
    result_t got, want;
    got.key       = out_tdata[KEY_W-1:0];
    got.tag       = out_tdata[KEY_W +: TAG_WIDTH];
    got.occupancy = out_tdata[KEY_W + TAG_WIDTH +: CNT_W];
    got.status    = out_tuser;
    results_seen++;
    if (pending_results.size() == 0) begin
      $display("%0t: result word with nothing expected: key=%h tag=%h status=%0d occ=%0d",
               $time, got.key, got.tag, got.status, got.occupancy);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.key !== want.key) begin
      $display("%0t: key mismatch: expected %h, actual %h", $time, want.key, got.key);
      errors++;
    end
    if (got.tag !== want.tag) begin
      $display("%0t: tag mismatch: expected %h, actual %h", $time, want.tag, got.tag);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status,
               got.status);
      errors++;
    end
    if (got.occupancy !== want.occupancy) begin
      $display("%0t: occupancy mismatch: expected %0d, actual %0d", $time, want.occupancy,
               got.occupancy);
      errors++;
    end
  endtask

  // Result side: random stalls plus one long hold-off that backs up the input.
  initial begin
    int  hold_left;
    bit  long_hold_done;
    hold_left = 0;
    long_hold_done = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result();
      if (hold_left > 0) begin
        hold_left--;
      end else if (!long_hold_done && results_seen >= 120) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 10);
      end
      out_tready <= rst_n && (hold_left == 0);
    end
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_INSERT;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    model_count = 0;
    model_larger_first = 1'b0;
    idle_on = 1;

    // Smaller key first after reset; the tie rows check that equal keys come out in the order the
    // heap predictor gives, and the unused code leaves the heap alone.
    opening_rows = '{
      '{FUNC_POP,    '0, '0, 1'b1, '{'0, '0, STAT_EMPTY, 9'd0}},
      '{FUNC_PEEK,   '0, '0, 1'b1, '{'0, '0, STAT_EMPTY, 9'd0}},
      '{FUNC_UNUSED, '1, '1, 1'b1, '{'0, '0, STAT_DONE, 9'd0}},
      '{FUNC_INSERT, '1, '1, 1'b1, '{'0, '0, STAT_DONE, 9'd1}},
      '{FUNC_INSERT, '0, '0, 1'b1, '{'0, '0, STAT_DONE, 9'd2}},
      '{FUNC_PEEK,   '0, '0, 1'b1, '{'0, '0, STAT_DONE, 9'd2}},
      '{FUNC_INSERT, 64'd5, 32'hA1, 1'b0, '0},
      '{FUNC_INSERT, 64'd5, 32'hA2, 1'b0, '0},
      '{FUNC_INSERT, 64'd5, 32'hA3, 1'b0, '0},
      '{FUNC_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0, '0},
      '{FUNC_INSERT, 64'd1, 32'd1, 1'b0, '0},
      '{FUNC_UNUSED, 64'd7, 32'd7, 1'b0, '0},
      '{FUNC_POP,    '0, '0, 1'b0, '0},
      '{FUNC_POP,    '0, '0, 1'b0, '0},
      '{FUNC_POP,    '0, '0, 1'b0, '0},
      '{FUNC_POP,    '0, '0, 1'b0, '0},
      '{FUNC_POP,    '0, '0, 1'b0, '0},
      '{FUNC_POP,    '0, '0, 1'b0, '0},
      '{FUNC_POP,    '0, '0, 1'b0, '0},
      '{FUNC_POP,    '0, '0, 1'b1, '{'0, '0, STAT_EMPTY, 9'd0}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[i])
      offer_word(opening_rows[i].func, opening_rows[i].key, opening_rows[i].tag,
                 opening_rows[i].typed, opening_rows[i].want);

    set_order_mode(1'b1);
    run_mixed(150);

    // Fill to capacity, push past it, then drain under the opposite order setting.
    set_order_mode(1'b0);
    while (model_count < HEAP_DEPTH) begin
      if ($urandom_range(0, 9) == 0) offer_random(FUNC_PEEK);
      else offer_random(FUNC_INSERT);
    end
    repeat (6) offer_random(FUNC_INSERT);
    run_mixed(80);
    set_order_mode(1'b1);
    while (model_count > 0) begin
      if ($urandom_range(0, 9) == 0) offer_random(FUNC_PEEK);
      else offer_random(FUNC_POP);
    end
    repeat (2) offer_random(FUNC_POP);

    set_order_mode(1'b0);
    idle_on = 0;
    run_mixed(60);

    wait_drained();
    $display("Sent %0d words: %0d inserts (%0d refused on a full heap), %0d pops, %0d peeks,",
             words_sent, n_insert, n_full, n_pop, n_peek);
    $display("%0d requests on an empty heap; both key orders, long output stall included.",
             n_empty);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bhpq_pkg.sv
rtl/bhpq_ram.sv
rtl/binary_heap_priority_queue.sv
rtl/bhpq_checker.sv
test/binary_heap_priority_queue_tb.sv
